### hw/rtl/iac_pkg.sv
package iac_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_CARD  = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	localparam logic [3:0] EV_NONE     = 4'd0;
	localparam logic [3:0] EV_GRANTED  = 4'd1;
	localparam logic [3:0] EV_SILENCED = 4'd2;
	localparam logic [3:0] EV_REJ_ALM  = 4'd3;
	localparam logic [3:0] EV_REJ_IDLE = 4'd4;
	localparam logic [3:0] EV_ENROLL   = 4'd5;
	localparam logic [3:0] EV_DOOR_AUTH = 4'd6;
	localparam logic [3:0] EV_FORCED   = 4'd7;
	localparam logic [3:0] EV_CLOSED   = 4'd8;
	localparam logic [3:0] EV_MOT_ALM  = 4'd9;
	localparam logic [3:0] EV_MOT_CNT  = 4'd10;

	localparam logic [2:0] CH_NONE   = 3'd0;
	localparam logic [2:0] CH_SHORT  = 3'd1;
	localparam logic [2:0] CH_ENTRY  = 3'd2;
	localparam logic [2:0] CH_ENROLL = 3'd3;
	localparam logic [2:0] CH_FAIL   = 3'd4;
	localparam logic [2:0] CH_ALARM  = 3'd5;

	localparam logic [2:0] REG_ARM      = 3'd0;
	localparam logic [2:0] REG_ENROLL   = 3'd1;
	localparam logic [2:0] REG_TRIG_N   = 3'd2;
	localparam logic [2:0] REG_WINDOW   = 3'd3;
	localparam logic [2:0] REG_GAP      = 3'd4;
	localparam logic [2:0] REG_AUTH     = 3'd5;
	localparam logic [2:0] REG_DEBOUNCE = 3'd6;
	localparam logic [2:0] REG_HOLDOFF  = 3'd7;

	localparam logic [16:0] SAT17 = 17'h1FFFF;
	localparam logic [10:0] DEBOUNCE_CAP = 11'd1024;
	localparam logic [2:0] SEGS_PER_TONE = 3'd6;

	typedef struct packed {
		logic [1:0]  cmd;
		logic        door_level;
		logic        motion_level;
		logic [59:0] key;
		logic [5:0]  slot;
	} item_t;

	function automatic logic [59:0] uid_key(input logic [55:0] uid, input logic [2:0] nb);
		logic [55:0] mask;
		begin
			mask = (nb == 3'd7) ? 56'hFF_FFFF_FFFF_FFFF : ((56'd1 << {nb, 3'b000}) - 56'd1);
			uid_key = {1'b1, nb, uid & mask};
		end
	endfunction

endpackage

### hw/rtl/iac_front.sv
module iac_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic                 door_level,
	input  logic                 motion_level,
	input  logic [55:0]          card_uid,
	input  logic [2:0]           uid_bytes,
	input  logic [5:0]           slot,
	output logic                 q_valid,
	input  logic                 q_pop,
	output iac_pkg::item_t       q_item
);
	import iac_pkg::*;

	// Two-entry queue between intake and the executing back end.
	item_t  mem_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	logic   push;

	assign in_ready = (cnt_q != 2'd2);
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= '{cmd: cmd, door_level: door_level, motion_level: motion_level,
				key: uid_key(card_uid, uid_bytes), slot: slot};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### hw/rtl/iac_back.sv
module iac_back #(
	parameter int CARD_SLOTS = 64,
	parameter int PIR_READY_MS = 5000,
	parameter int SIREN_SEGMENT_MS = 60
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [2:0]     cfg_idx,
	input  logic [15:0]    cfg_data,
	input  logic           q_valid,
	output logic           q_pop,
	input  iac_pkg::item_t q_item,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [3:0]     event_res,
	output logic [2:0]     chime,
	output logic           alarm_on,
	output logic           siren_high,
	output logic           camera_pulse,
	output logic           report,
	output logic [5:0]     matched_slot,
	output logic           last
);
	import iac_pkg::*;

	localparam int SW = (CARD_SLOTS > 1) ? $clog2(CARD_SLOTS) : 1;
	localparam int CW = $clog2(CARD_SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_WAIT, ST_CLEAR, ST_OUT0, ST_OUT1
	} state_t;

	typedef struct packed {
		logic [3:0] ev;
		logic [2:0] ch;
		logic       cam;
		logic       rep;
		logic [5:0] slot;
	} res_t;

	// Configuration registers.
	logic [1:0]  arm_mode_q;
	logic        enroll_q;
	logic [3:0]  trig_n_q;
	logic [15:0] window_ms_q, gap_ms_q, auth_ms_q, holdoff_q;
	logic [9:0]  debounce_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_mode_q <= 2'd0;
			enroll_q <= 1'b0;
			trig_n_q <= 4'd1;
			window_ms_q <= 16'd15000;
			gap_ms_q <= 16'd3000;
			auth_ms_q <= 16'd20000;
			debounce_ms_q <= 10'd50;
			holdoff_q <= 16'd60000;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ARM:      arm_mode_q <= cfg_data[1:0];
				REG_ENROLL:   enroll_q <= cfg_data[0];
				REG_TRIG_N:   trig_n_q <= cfg_data[3:0];
				REG_WINDOW:   window_ms_q <= cfg_data;
				REG_GAP:      gap_ms_q <= cfg_data;
				REG_AUTH:     auth_ms_q <= cfg_data;
				REG_DEBOUNCE: debounce_ms_q <= cfg_data[9:0];
				REG_HOLDOFF:  holdoff_q <= cfg_data;
				default: ;
			endcase
		end
	end

	wire armed = (arm_mode_q == 2'd1) || (arm_mode_q == 2'd2);

	// Card table memory, emptied by a clearing pass after reset and for the clear command.
	logic [59:0] table_mem [CARD_SLOTS];
	logic [59:0] rd_s1;
	logic [SW-1:0] rd_addr;
	logic          mem_we;
	logic [SW-1:0] mem_wa;
	logic [59:0]   mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) table_mem[mem_wa] <= mem_wd;
		rd_s1 <= table_mem[rd_addr];
	end

	// Control and state.
	state_t state_q;
	logic [CW-1:0] idx_q;
	logic [SW-1:0] cmp_idx_q;
	logic          cmp_vld_q;
	logic          clr_done_q;
	item_t         it_q;
	res_t          r0_q, r1_q;
	logic          two_q;

	logic        alarm_q, door_raw_q;
	logic [1:0]  door_stable_q;
	logic [10:0] deb_q;
	logic [15:0] auth_q;
	logic [12:0] warm_q;
	logic [16:0] gap_q, win_q, dalert_q, malert_q;
	logic [3:0]  tcount_q;
	logic        dseen_q, mseen_q;
	logic        siren_q;
	logic [9:0]  siren_ms_q;
	logic [2:0]  siren_seg_q;

	// Tick processing, combinational from current state.
	logic        t_alarm, t_raw, t_dseen, t_mseen, t_siren;
	logic [1:0]  t_stable;
	logic [10:0] t_deb;
	logic [15:0] t_auth;
	logic [12:0] t_warm;
	logic [16:0] t_gap, t_win, t_dal, t_mal;
	logic [3:0]  t_cnt;
	logic [9:0]  t_sms;
	logic [2:0]  t_sseg;
	res_t        t_r0, t_r1;
	logic [1:0]  t_n;

	function automatic logic [16:0] sat_inc(input logic [16:0] v);
		sat_inc = (v < SAT17) ? v + 17'd1 : v;
	endfunction

	always_comb begin
		logic auth_now, alm_in;
		logic [2:0] ch;
		logic rep;
		res_t ev;
		alm_in = armed ? alarm_q : 1'b0;
		t_alarm = alm_in;
		t_auth = (auth_q != 16'd0) ? auth_q - 16'd1 : auth_q;
		t_warm = (warm_q != 13'd0) ? warm_q - 13'd1 : warm_q;
		t_gap = (gap_q != 17'd0) ? sat_inc(gap_q) : gap_q;
		t_win = sat_inc(win_q);
		t_dal = sat_inc(dalert_q);
		t_mal = sat_inc(malert_q);
		t_deb = (deb_q < DEBOUNCE_CAP) ? deb_q + 11'd1 : deb_q;
		auth_now = (t_auth != 16'd0);
		t_raw = door_raw_q;
		t_stable = door_stable_q;
		t_dseen = dseen_q;
		t_mseen = mseen_q;
		t_cnt = tcount_q;
		t_r0 = '0;
		t_r1 = '0;
		t_n = 2'd0;
		ch = CH_NONE;
		rep = 1'b0;
		ev = '0;
		if (it_q.door_level != door_raw_q) begin
			t_raw = it_q.door_level;
			t_deb = 11'd0;
		end
		if ({1'b0, t_raw} != t_stable && t_deb > {1'b0, debounce_ms_q}) begin
			t_stable = {1'b0, t_raw};
			if (armed) begin
				if (t_raw) begin
					if (auth_now) begin
						ev = '{ev: EV_DOOR_AUTH, ch: CH_SHORT, cam: 1'b0, rep: 1'b1, slot: 6'd0};
					end else begin
						ch = t_alarm ? CH_NONE : CH_ALARM;
						t_alarm = 1'b1;
						if (!t_dseen || t_dal > {1'b0, holdoff_q}) begin
							t_dseen = 1'b1;
							t_dal = 17'd0;
							rep = 1'b1;
						end
						ev = '{ev: EV_FORCED, ch: ch, cam: 1'b1, rep: rep, slot: 6'd0};
					end
				end else begin
					ev = '{ev: EV_CLOSED, ch: auth_now ? CH_SHORT : CH_NONE, cam: 1'b0,
						rep: 1'b0, slot: 6'd0};
				end
				t_r0 = ev;
				t_n = 2'd1;
			end
		end
		if (it_q.motion_level && arm_mode_q == 2'd2 && t_warm == 13'd0 && !auth_now &&
			!(t_gap != 17'd0 && (t_gap - 17'd1) < {1'b0, gap_ms_q})) begin
			t_gap = 17'd1;
			if (t_cnt == 4'd0 || t_win > {1'b0, window_ms_q}) begin
				t_cnt = 4'd1;
				t_win = 17'd0;
			end else if (t_cnt < 4'd15) begin
				t_cnt = t_cnt + 4'd1;
			end
			if (t_cnt < trig_n_q) begin
				ev = '{ev: EV_MOT_CNT, ch: CH_NONE, cam: 1'b1, rep: 1'b0, slot: 6'd0};
			end else begin
				t_cnt = 4'd0;
				ch = t_alarm ? CH_NONE : CH_ALARM;
				t_alarm = 1'b1;
				rep = 1'b0;
				if (!t_mseen || t_mal > {1'b0, holdoff_q}) begin
					t_mseen = 1'b1;
					t_mal = 17'd0;
					rep = 1'b1;
				end
				ev = '{ev: EV_MOT_ALM, ch: ch, cam: 1'b1, rep: rep, slot: 6'd0};
			end
			if (t_n == 2'd0) t_r0 = ev;
			else t_r1 = ev;
			t_n = t_n + 2'd1;
		end
		t_sms = siren_ms_q;
		t_sseg = siren_seg_q;
		t_siren = siren_q;
		if (t_alarm) begin
			if (siren_ms_q + 10'd1 >= 10'(SIREN_SEGMENT_MS)) begin
				t_sms = 10'd0;
				if (siren_seg_q + 3'd1 >= SEGS_PER_TONE) begin
					t_sseg = 3'd0;
					t_siren = ~siren_q;
				end else begin
					t_sseg = siren_seg_q + 3'd1;
				end
			end else begin
				t_sms = siren_ms_q + 10'd1;
			end
		end
	end

	wire hit = cmp_vld_q && (rd_s1 == it_q.key);
	wire scan_end = (idx_q == CW'(CARD_SLOTS));

	always_comb begin
		rd_addr = idx_q[SW-1:0];
		mem_we = 1'b0;
		mem_wa = SW'(it_q.slot);
		mem_wd = it_q.key;
		if (state_q == ST_IDLE && q_valid && q_item.cmd == CMD_WRITE
			&& {3'b000, q_item.slot} < 9'(CARD_SLOTS)) begin
			mem_we = 1'b1;
			mem_wa = SW'(q_item.slot);
			mem_wd = q_item.key;
		end else if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = idx_q[SW-1:0];
			mem_wd = '0;
		end
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q <= '0;
			cmp_idx_q <= '0;
			cmp_vld_q <= 1'b0;
			clr_done_q <= 1'b0;
			two_q <= 1'b0;
			alarm_q <= 1'b0;
			door_raw_q <= 1'b0;
			door_stable_q <= 2'd2;
			deb_q <= '0;
			auth_q <= '0;
			warm_q <= 13'(PIR_READY_MS);
			gap_q <= '0;
			win_q <= '0;
			tcount_q <= '0;
			dalert_q <= '0;
			malert_q <= '0;
			dseen_q <= 1'b0;
			mseen_q <= 1'b0;
			siren_q <= 1'b0;
			siren_ms_q <= '0;
			siren_seg_q <= '0;
			it_q <= '0;
			r0_q <= '0;
			r1_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						it_q <= q_item;
						idx_q <= '0;
						cmp_vld_q <= 1'b0;
						if (!armed) alarm_q <= 1'b0;
						r0_q <= '0;
						two_q <= 1'b0;
						unique case (q_item.cmd)
							CMD_TICK:  state_q <= ST_WAIT;
							CMD_CARD:  state_q <= ST_SCAN;
							CMD_WRITE: state_q <= ST_OUT0;
							CMD_CLEAR: state_q <= ST_CLEAR;
							default:   state_q <= ST_OUT0;
						endcase
					end
				end
				ST_WAIT: begin
					// Tick: commit all timer updates at once.
					alarm_q <= t_alarm;
					door_raw_q <= t_raw;
					door_stable_q <= t_stable;
					deb_q <= t_deb;
					auth_q <= t_auth;
					warm_q <= t_warm;
					gap_q <= t_gap;
					win_q <= t_win;
					tcount_q <= t_cnt;
					dalert_q <= t_dal;
					malert_q <= t_mal;
					dseen_q <= t_dseen;
					mseen_q <= t_mseen;
					siren_q <= t_siren;
					siren_ms_q <= t_sms;
					siren_seg_q <= t_sseg;
					r0_q <= t_r0;
					r1_q <= t_r1;
					two_q <= (t_n == 2'd2);
					state_q <= ST_OUT0;
				end
				ST_SCAN: begin
					cmp_vld_q <= !scan_end;
					cmp_idx_q <= idx_q[SW-1:0];
					if (!scan_end) idx_q <= idx_q + CW'(1);
					if (hit) begin
						alarm_q <= 1'b0;
						auth_q <= auth_ms_q;
						tcount_q <= 4'd0;
						r0_q <= '{ev: alarm_q ? EV_SILENCED : EV_GRANTED, ch: CH_ENTRY,
							cam: 1'b0, rep: 1'b1, slot: 6'(cmp_idx_q)};
						state_q <= ST_OUT0;
					end else if (!cmp_vld_q && scan_end) begin
						if (enroll_q) begin
							r0_q <= '{ev: EV_ENROLL, ch: CH_ENROLL, cam: 1'b0, rep: 1'b0,
								slot: 6'd0};
						end else if (armed) begin
							alarm_q <= 1'b1;
							r0_q <= '{ev: EV_REJ_ALM, ch: alarm_q ? CH_NONE : CH_ALARM,
								cam: 1'b1, rep: 1'b1, slot: 6'd0};
						end else begin
							r0_q <= '{ev: EV_REJ_IDLE, ch: CH_FAIL, cam: 1'b0, rep: 1'b0,
								slot: 6'd0};
						end
						state_q <= ST_OUT0;
					end
				end
				ST_CLEAR: begin
					// The pass after reset ends silently; a clear command gives a result.
					if (idx_q == CW'(CARD_SLOTS - 1)) begin
						state_q <= clr_done_q ? ST_OUT0 : ST_IDLE;
						clr_done_q <= 1'b1;
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				ST_OUT0: begin
					if (out_ready) state_q <= two_q ? ST_OUT1 : ST_IDLE;
				end
				ST_OUT1: begin
					if (out_ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	res_t cur;
	assign cur = (state_q == ST_OUT1) ? r1_q : r0_q;
	assign out_valid = (state_q == ST_OUT0) || (state_q == ST_OUT1);
	assign event_res = cur.ev;
	assign chime = cur.ch;
	assign camera_pulse = cur.cam;
	assign report = cur.rep;
	assign matched_slot = cur.slot;
	assign alarm_on = alarm_q;
	assign siren_high = siren_q;
	assign last = (state_q == ST_OUT1) || !two_q;
endmodule

### hw/rtl/intrusion_alarm_controller_unit.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    cmd, door_level, motion_level, card_uid,
//                                             uid_bytes, slot
// out       output     out_valid / out_ready  event_res, chime, alarm_on, siren_high,
//                                             camera_pulse, report, matched_slot, last
// cfg       input      cfg_we                 cfg_index, cfg_data
//
// A tick commits its timer updates in ST_WAIT, then delivers one or two results; a slot
// write goes to the table as it is taken and gives one result. A card presentation scans
// the table one slot per cycle through the memory read port; a table clear sweeps every slot.
// Reset is asynchronous and clears all control state and timers; after it a
// clearing pass empties the table before the first item is taken.
// A two-entry queue lets the input side accept up to two transfers while results stall.
module intrusion_alarm_controller_unit #(
	parameter int CARD_SLOTS = 64,
	parameter int PIR_READY_MS = 5000,
	parameter int SIREN_SEGMENT_MS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic        door_level,
	input  logic        motion_level,
	input  logic [55:0] card_uid,
	input  logic [2:0]  uid_bytes,
	input  logic [5:0]  slot,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  event_res,
	output logic [2:0]  chime,
	output logic        alarm_on,
	output logic        siren_high,
	output logic        camera_pulse,
	output logic        report,
	output logic [5:0]  matched_slot,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import iac_pkg::*;

	item_t q_item;
	logic  q_valid, q_pop;

	// The front end packs each transfer into a table key and queues it.
	iac_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .cmd, .door_level, .motion_level,
		.card_uid, .uid_bytes, .slot, .q_valid, .q_pop, .q_item
	);

	// The back end runs timers, the table scan and result delivery.
	iac_back #(
		.CARD_SLOTS(CARD_SLOTS), .PIR_READY_MS(PIR_READY_MS),
		.SIREN_SEGMENT_MS(SIREN_SEGMENT_MS)
	) u_back (
		.clk, .arst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data, .q_valid, .q_pop, .q_item,
		.out_valid, .out_ready, .event_res, .chime, .alarm_on, .siren_high,
		.camera_pulse, .report, .matched_slot, .last
	);
endmodule
